### src/evcp_pkg.sv
// evcp_pkg: shared types, codes and step helpers for the control pilot block.
// No dependencies.
`default_nettype none
package evcp_pkg;

    localparam int VOLT_WINDOW_MV_DEF = 1100;
    localparam int MAX_EV = 5;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [2:0] ST_DIS = 3'd0;
    localparam logic [2:0] ST_A   = 3'd1;
    localparam logic [2:0] ST_B   = 3'd2;
    localparam logic [2:0] ST_C   = 3'd3;
    localparam logic [2:0] ST_D   = 3'd4;
    localparam logic [2:0] ST_E   = 3'd5;
    localparam logic [2:0] ST_F   = 3'd6;
    localparam logic [2:0] ST_DF  = 3'd7;

    localparam logic [2:0] MODE_STEP    = 3'd0;
    localparam logic [2:0] MODE_ENABLE  = 3'd1;
    localparam logic [2:0] MODE_DISABLE = 3'd2;
    localparam logic [2:0] MODE_PWM_ON  = 3'd3;
    localparam logic [2:0] MODE_PWM_OFF = 3'd4;
    localparam logic [2:0] MODE_PWM_F   = 3'd5;
    localparam logic [2:0] MODE_ALLOW   = 3'd6;
    localparam logic [2:0] MODE_DENY    = 3'd7;

    localparam logic [3:0] EV_PLUGGED   = 4'd0;
    localparam logic [3:0] EV_REQ_POWER = 4'd1;
    localparam logic [3:0] EV_POWER_ON  = 4'd2;
    localparam logic [3:0] EV_POWER_OFF = 4'd3;
    localparam logic [3:0] EV_REQ_STOP  = 4'd4;
    localparam logic [3:0] EV_UNPLUGGED = 4'd5;
    localparam logic [3:0] EV_ERR_E     = 4'd6;
    localparam logic [3:0] EV_ERR_DF    = 4'd7;
    localparam logic [3:0] EV_RELAY_ERR = 4'd8;
    localparam logic [3:0] EV_RCD_ERR   = 4'd9;
    localparam logic [3:0] EV_NO_VENT   = 4'd10;
    localparam logic [3:0] EV_EF_TO_BCD = 4'd11;
    localparam logic [3:0] EV_BCD_TO_EF = 4'd12;

    localparam logic [1:0] RELAY_NONE  = 2'd0;
    localparam logic [1:0] RELAY_CLOSE = 2'd1;
    localparam logic [1:0] RELAY_OPEN  = 2'd2;
    localparam logic [1:0] LOCK_NONE   = 2'd0;
    localparam logic [1:0] LOCK_LOCK   = 2'd1;
    localparam logic [1:0] LOCK_UNLOCK = 2'd2;

    localparam logic [2:0] CFG_THREE_PHASE = 3'd0;
    localparam logic [2:0] CFG_VENT        = 3'd1;
    localparam logic [2:0] CFG_RCD_RECLOSE = 3'd2;
    localparam logic [2:0] CFG_PWM_STOP    = 3'd3;
    localparam logic [2:0] CFG_LOCK_REL    = 3'd4;

    localparam logic [9:0] DUTY_FULL = 10'd1000;

    typedef struct packed {
        logic                    relay_on;
        logic                    sw_ok;
        logic [1:0]              relay_cmd;
        logic                    relay_3ph;
        logic [1:0]              lock_cmd;
        logic                    lock_run;
        logic [31:0]             lock_start;
        logic [2:0]              ev_cnt;
        logic [MAX_EV-1:0][3:0]  ev;
    } work_t;

    typedef struct packed {
        logic [2:0]              ev_cnt;
        logic [MAX_EV-1:0][3:0]  ev;
        logic [1:0]              relay_cmd;
        logic                    relay_3ph;
        logic [1:0]              lock_cmd;
        logic                    rcd_clear;
        logic                    emerg_reset;
        logic [9:0]              duty;
        logic                    cp_en;
        logic [2:0]              state;
    } record_t;

    function automatic work_t emit(work_t w, logic [3:0] code);
        work_t r;
        r = w;
        if (w.ev_cnt < 3'(MAX_EV))
        begin
            r.ev[w.ev_cnt] = code;
            r.ev_cnt = w.ev_cnt + 3'd1;
        end
        return r;
    endfunction

    function automatic work_t close_relay(work_t w, logic latch, logic [31:0] now);
        work_t r;
        r = w;
        if (!w.relay_on)
        begin
            r.relay_cmd = RELAY_CLOSE;
            r.relay_3ph = latch;
            r = emit(r, w.sw_ok ? EV_POWER_ON : EV_RELAY_ERR);
            if (w.sw_ok)
                r.relay_on = 1'b1;
            r.lock_cmd = LOCK_LOCK;
            r.lock_run = 1'b1;
            r.lock_start = now;
        end
        return r;
    endfunction

    function automatic work_t open_relay(work_t w, logic [31:0] now);
        work_t r;
        r = w;
        if (w.relay_on)
        begin
            r.relay_cmd = RELAY_OPEN;
            r.relay_3ph = 1'b0;
            r = emit(r, w.sw_ok ? EV_POWER_OFF : EV_RELAY_ERR);
            if (w.sw_ok)
                r.relay_on = 1'b0;
            r.lock_cmd = LOCK_UNLOCK;
            r.lock_run = 1'b1;
            r.lock_start = now;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### src/evse_control_pilot_fsm.sv
// Control pilot state machine for a charging station, top level.
// Depends on evcp_pkg, evcp_front, evcp_queue, evcp_back.
//
// One input transfer is one step or command; it is handled in the cycle it is accepted and
// yields zero to five event transfers followed by one status transfer (tlast). The front
// accepts a new step every cycle while the two-entry record queue has room. A step yields
// 1 to 6 output items, sent by the one-item-per-cycle output port while m_axis_tready is high.
// Configuration writes are always ready and should be made while idle.
`default_nettype none
module evse_control_pilot_fsm
    import evcp_pkg::*;
#(
    parameter int VOLT_WINDOW_MV = VOLT_WINDOW_MV_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // cp_high_mv[14:0], cp_low_mv[29:15], cp_valid[30], rcd_fired[31], relay_closed[32],
    // relay_ok[33], now_ticks[65:34], duty_permille[75:66], zero fill
    input  wire logic [79:0] s_axis_tdata,
    // mode[2:0]
    input  wire logic [2:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // event_code[3:0], relay_cmd[5:4], relay_three_phase[6], lock_cmd[8:7],
    // rcd_flag_clear[9], emergency_reset[10], pwm_duty_out[20:11], cp_enable_out[21],
    // cp_state[24:22], zero fill
    output logic [31:0]      m_axis_tdata,
    // event_valid[0]
    output logic [0:0]       m_axis_tuser,
    output logic             m_axis_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    record_t rec, head;
    logic    full, empty, pop, in_fire;

    assign s_axis_tready = !full;
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign cfg_ready = 1'b1;

    evcp_front #(.VOLT_WINDOW_MV(VOLT_WINDOW_MV)) u_front (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire),
        .mode(s_axis_tuser),
        .cp_high_mv(s_axis_tdata[14:0]),
        .cp_low_mv(s_axis_tdata[29:15]),
        .cp_valid(s_axis_tdata[30]),
        .rcd_fired(s_axis_tdata[31]),
        .relay_closed(s_axis_tdata[32]),
        .relay_ok(s_axis_tdata[33]),
        .now_ticks(s_axis_tdata[65:34]),
        .duty_permille(s_axis_tdata[75:66]),
        .cfg_fire(cfg_valid && cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .rec(rec)
    );

    evcp_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(in_fire), .push_rec(rec), .pop(pop),
        .full(full), .empty(empty), .head(head)
    );

    evcp_back u_back (
        .clk(clk), .rst_n(rst_n), .empty(empty), .head(head), .pop(pop),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );
endmodule
`default_nettype wire

### src/evcp_front.sv
// evcp_front: accepts steps and commands, runs the pilot state machine, builds one record.
// Depends on evcp_pkg.
`default_nettype none
module evcp_front
    import evcp_pkg::*;
#(
    parameter int VOLT_WINDOW_MV = VOLT_WINDOW_MV_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_fire,
    input  wire logic [2:0]  mode,
    input  wire logic [14:0] cp_high_mv,
    input  wire logic [14:0] cp_low_mv,
    input  wire logic        cp_valid,
    input  wire logic        rcd_fired,
    input  wire logic        relay_closed,
    input  wire logic        relay_ok,
    input  wire logic [31:0] now_ticks,
    input  wire logic [9:0]  duty_permille,
    input  wire logic        cfg_fire,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output record_t          rec
);
    localparam logic signed [17:0] WIN = 18'(VOLT_WINDOW_MV);

    function automatic logic near(logic signed [17:0] v, logic signed [17:0] c);
        return (v > c - WIN) && (v < c + WIN);
    endfunction

    logic        three_ph_reg, vent_reg, reclose_reg;
    logic [31:0] stop_ticks_reg, lock_ticks_reg;
    logic [2:0]  cur_reg, cur_next, prev_reg, prev_next;
    logic        pwm_run_reg, pwm_run_next, pwm_was_reg, pwm_was_next;
    logic        allow_reg, allow_next, simpl_reg, simpl_next;
    logic        latch_reg, latch_next, cp_en_reg, cp_en_next;
    logic [9:0]  duty_reg, duty_next;
    logic        stop_run_reg, stop_run_next;
    logic [31:0] stop_start_reg, stop_start_next;
    logic        lock_run_reg;
    logic [31:0] lock_start_reg;
    work_t       w;
    logic        rcd_clr, emerg, cls_ok;
    logic [2:0]  st;
    logic signed [17:0] hi, lo, sum;

    always_comb
    begin
        cur_next = cur_reg;
        prev_next = prev_reg;
        pwm_run_next = pwm_run_reg;
        pwm_was_next = pwm_was_reg;
        allow_next = allow_reg;
        simpl_next = simpl_reg;
        latch_next = latch_reg;
        cp_en_next = cp_en_reg;
        duty_next = duty_reg;
        stop_run_next = stop_run_reg;
        stop_start_next = stop_start_reg;
        w = '0;
        w.relay_on = relay_closed;
        w.sw_ok = relay_ok;
        w.lock_run = lock_run_reg;
        w.lock_start = lock_start_reg;
        rcd_clr = 1'b0;
        emerg = 1'b0;
        hi = 18'(signed'(cp_high_mv));
        lo = 18'(signed'(cp_low_mv));
        sum = hi + lo;
        cls_ok = 1'b1;
        st = ST_DIS;
        case (mode)
            MODE_STEP:
            begin
                if (rcd_fired)
                begin
                    rcd_clr = 1'b1;
                    w = emit(w, EV_RCD_ERR);
                end
                if (w.lock_run && (now_ticks - w.lock_start) >= lock_ticks_reg)
                begin
                    w.lock_cmd = LOCK_UNLOCK;
                    w.lock_run = 1'b0;
                end
                if (cur_reg == ST_DIS)
                    st = ST_DIS;
                else if (pwm_run_reg && !near(lo, -18'sd12000))
                begin
                    if (near(lo, 18'sd0) && near(hi, 18'sd0))
                        st = ST_E;
                    else if (near(sum, 18'sd0))
                        st = ST_DF;
                    else
                        cls_ok = 1'b0;
                end
                else if (near(hi, 18'sd12000))
                    st = ST_A;
                else if (near(hi, 18'sd9000))
                    st = ST_B;
                else if (near(hi, 18'sd6000))
                    st = ST_C;
                else if (near(hi, 18'sd3000))
                    st = ST_D;
                else if (near(hi, -18'sd12000))
                    st = ST_F;
                else
                    cls_ok = 1'b0;
                if (cp_valid && cls_ok)
                begin
                    cur_next = st;
                    case (st)
                        ST_DIS:
                        begin
                            allow_next = 1'b0;
                            w = open_relay(w, now_ticks);
                        end
                        ST_A:
                        begin
                            latch_next = three_ph_reg;
                            duty_next = DUTY_FULL;
                            pwm_run_next = 1'b0;
                            allow_next = 1'b0;
                            simpl_next = 1'b0;
                            if (prev_reg != ST_A && prev_reg != ST_DIS && prev_reg != ST_F)
                            begin
                                w = emit(w, EV_REQ_STOP);
                                w = open_relay(w, now_ticks);
                                w = emit(w, EV_UNPLUGGED);
                                if (reclose_reg)
                                begin
                                    emerg = 1'b1;
                                    rcd_clr = 1'b1;
                                end
                            end
                        end
                        ST_B:
                        begin
                            if (prev_reg != ST_A && prev_reg != ST_B)
                            begin
                                w = emit(w, EV_REQ_STOP);
                                w = open_relay(w, now_ticks);
                            end
                            if (prev_reg == ST_A || prev_reg == ST_DIS)
                            begin
                                w = emit(w, EV_PLUGGED);
                                simpl_next = 1'b0;
                            end
                            if (prev_reg == ST_E || prev_reg == ST_F)
                                w = emit(w, EV_EF_TO_BCD);
                        end
                        ST_C, ST_D:
                        begin
                            if (prev_reg == ST_A)
                            begin
                                w = emit(w, EV_PLUGGED);
                                if (st == ST_D)
                                    w = emit(w, EV_REQ_POWER);
                                simpl_next = 1'b1;
                            end
                            if (prev_reg == ST_B)
                                w = emit(w, EV_REQ_POWER);
                            if (prev_reg == ST_E || prev_reg == ST_F)
                                w = emit(w, EV_EF_TO_BCD);
                            if (!pwm_run_reg)
                            begin
                                if (pwm_was_reg)
                                begin
                                    stop_run_next = 1'b1;
                                    stop_start_next = now_ticks;
                                end
                                if (stop_run_next &&
                                    (now_ticks - stop_start_next) >= stop_ticks_reg)
                                    w = open_relay(w, now_ticks);
                            end
                            else if (st == ST_C)
                            begin
                                if (allow_reg)
                                begin
                                    w = close_relay(w, latch_reg, now_ticks);
                                    if (!pwm_was_reg && simpl_next)
                                        w = emit(w, EV_REQ_POWER);
                                end
                            end
                            else
                            begin
                                if (allow_reg && !w.relay_on)
                                begin
                                    if (!vent_reg)
                                        w = emit(w, EV_NO_VENT);
                                    else
                                        w = close_relay(w, latch_reg, now_ticks);
                                end
                                if (prev_reg == ST_C && !vent_reg)
                                    w = emit(w, EV_NO_VENT);
                            end
                        end
                        ST_E:
                        begin
                            if (prev_reg != ST_E)
                                w = emit(w, EV_ERR_E);
                            if (prev_reg == ST_B || prev_reg == ST_C || prev_reg == ST_D)
                                w = emit(w, EV_BCD_TO_EF);
                            w = open_relay(w, now_ticks);
                            duty_next = DUTY_FULL;
                            pwm_run_next = 1'b0;
                            allow_next = 1'b0;
                        end
                        ST_F:
                        begin
                            w = open_relay(w, now_ticks);
                            if (prev_reg == ST_B || prev_reg == ST_C || prev_reg == ST_D)
                                w = emit(w, EV_BCD_TO_EF);
                        end
                        default:
                        begin
                            if (prev_reg != ST_DF)
                                w = emit(w, EV_ERR_DF);
                            if (prev_reg == ST_B || prev_reg == ST_C || prev_reg == ST_D)
                                w = emit(w, EV_BCD_TO_EF);
                            w = open_relay(w, now_ticks);
                        end
                    endcase
                    prev_next = st;
                    pwm_was_next = pwm_run_next;
                end
            end
            MODE_ENABLE:
            begin
                cur_next = ST_A;
                duty_next = DUTY_FULL;
                pwm_run_next = 1'b0;
                allow_next = 1'b0;
                cp_en_next = 1'b1;
            end
            MODE_DISABLE:
            begin
                cur_next = ST_DIS;
                duty_next = DUTY_FULL;
                pwm_run_next = 1'b0;
                allow_next = 1'b0;
                cp_en_next = 1'b0;
            end
            MODE_PWM_ON:
            begin
                duty_next = (duty_permille > DUTY_FULL) ? DUTY_FULL : duty_permille;
                pwm_run_next = 1'b1;
            end
            MODE_PWM_OFF:
            begin
                duty_next = DUTY_FULL;
                pwm_run_next = 1'b0;
                allow_next = 1'b0;
            end
            MODE_PWM_F:
            begin
                duty_next = 10'd0;
                cur_next = ST_F;
                pwm_run_next = 1'b0;
                allow_next = 1'b0;
            end
            MODE_ALLOW: allow_next = 1'b1;
            default:    allow_next = 1'b0;
        endcase

        rec.ev_cnt = w.ev_cnt;
        rec.ev = w.ev;
        rec.relay_cmd = w.relay_cmd;
        rec.relay_3ph = (w.relay_cmd == RELAY_CLOSE) ? w.relay_3ph : 1'b0;
        rec.lock_cmd = w.lock_cmd;
        rec.rcd_clear = rcd_clr;
        rec.emerg_reset = emerg;
        rec.duty = duty_next;
        rec.cp_en = cp_en_next;
        rec.state = cur_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            three_ph_reg <= 1'b0;
            vent_reg <= 1'b0;
            reclose_reg <= 1'b1;
            stop_ticks_reg <= 32'd6000;
            lock_ticks_reg <= 32'd1000;
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                CFG_THREE_PHASE: three_ph_reg <= cfg_data[0];
                CFG_VENT:        vent_reg <= cfg_data[0];
                CFG_RCD_RECLOSE: reclose_reg <= cfg_data[0];
                CFG_PWM_STOP:    stop_ticks_reg <= cfg_data;
                CFG_LOCK_REL:    lock_ticks_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg <= ST_DIS;
            prev_reg <= ST_DIS;
            pwm_run_reg <= 1'b0;
            pwm_was_reg <= 1'b0;
            allow_reg <= 1'b0;
            simpl_reg <= 1'b0;
            latch_reg <= 1'b0;
            cp_en_reg <= 1'b0;
            duty_reg <= DUTY_FULL;
            stop_run_reg <= 1'b0;
            stop_start_reg <= '0;
            lock_run_reg <= 1'b0;
            lock_start_reg <= '0;
        end
        else if (in_fire)
        begin
            cur_reg <= cur_next;
            prev_reg <= prev_next;
            pwm_run_reg <= pwm_run_next;
            pwm_was_reg <= pwm_was_next;
            allow_reg <= allow_next;
            simpl_reg <= simpl_next;
            latch_reg <= latch_next;
            cp_en_reg <= cp_en_next;
            duty_reg <= duty_next;
            stop_run_reg <= stop_run_next;
            stop_start_reg <= stop_start_next;
            lock_run_reg <= w.lock_run;
            lock_start_reg <= w.lock_start;
        end
    end
endmodule
`default_nettype wire

### src/evcp_queue.sv
// evcp_queue: small FIFO of step records between front and back.
// Depends on evcp_pkg.
`default_nettype none
module evcp_queue
    import evcp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  record_t   push_rec,
    input  wire logic pop,
    output logic      full,
    output logic      empty,
    output record_t   head
);
    localparam int ADDR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    record_t           mem [QUEUE_DEPTH];
    logic [ADDR_W-1:0] wr_reg, rd_reg;
    logic [ADDR_W:0]   cnt_reg;

    assign full  = (cnt_reg == (ADDR_W+1)'(QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= push_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= (wr_reg == ADDR_W'(QUEUE_DEPTH-1)) ? '0 : wr_reg + 1'b1;
            if (pop)
                rd_reg <= (rd_reg == ADDR_W'(QUEUE_DEPTH-1)) ? '0 : rd_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end
endmodule
`default_nettype wire

### src/evcp_back.sv
// evcp_back: walks the head record and sends its event items, then the status item.
// Depends on evcp_pkg.
`default_nettype none
module evcp_back
    import evcp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        empty,
    input  record_t          head,
    output logic             pop,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,
    output logic [0:0]       m_axis_tuser,
    output logic             m_axis_tlast
);
    logic [2:0] idx_reg;
    logic       is_ev;

    assign is_ev = idx_reg < head.ev_cnt;
    assign m_axis_tvalid = !empty;
    assign m_axis_tlast = !is_ev;
    assign m_axis_tuser[0] = is_ev;
    assign pop = m_axis_tvalid && m_axis_tready && !is_ev;

    always_comb
    begin
        m_axis_tdata = '0;
        if (is_ev)
            m_axis_tdata[3:0] = head.ev[idx_reg];
        else
        begin
            m_axis_tdata[5:4]   = head.relay_cmd;
            m_axis_tdata[6]     = head.relay_3ph;
            m_axis_tdata[8:7]   = head.lock_cmd;
            m_axis_tdata[9]     = head.rcd_clear;
            m_axis_tdata[10]    = head.emerg_reset;
            m_axis_tdata[20:11] = head.duty;
            m_axis_tdata[21]    = head.cp_en;
            m_axis_tdata[24:22] = head.state;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else if (m_axis_tvalid && m_axis_tready)
            idx_reg <= is_ev ? idx_reg + 3'd1 : 3'd0;
    end
endmodule
`default_nettype wire

### src/evcp_checker.sv
// evcp_checker: port-level assertions for the control pilot block, bound to the top level.
// No package dependency.
`default_nettype none
module evcp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic [0:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed while stalled");

    a_event_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[31:4] == 28'd0 && !m_axis_tlast)
        else $error("event item carries status bits");

    a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[3:0] == 4'd0 && !m_axis_tuser[0])
        else $error("status item carries an event code");

    a_three_phase: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[6] |-> m_axis_tdata[5:4] == 2'd1)
        else $error("three phase without close");

    a_duty: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[20:11] <= 10'd1000)
        else $error("duty out of range");
endmodule

bind evse_control_pilot_fsm evcp_checker u_evcp_checker (
    .clk(clk), .rst_n(rst_n), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast)
);
`default_nettype wire

### bench/evse_control_pilot_fsm_tb.sv
// Testbench for evse_control_pilot_fsm: drives pilot steps and commands over the input
// stream and checks every event and status transfer against a built-in predictor.
// Depends on evcp_pkg and the evse_control_pilot_fsm RTL.
`timescale 1ns / 100ps
module evse_control_pilot_fsm_tb;
    import evcp_pkg::*;

    typedef struct packed {
        logic [2:0]  mode;
        logic [14:0] hi;
        logic [14:0] lo;
        logic        cpv;
        logic        rcd;
        logic        rclosed;
        logic        rok;
        logic [31:0] now;
        logic [9:0]  duty;
    } step_t;

    typedef struct packed {
        logic        evv;
        logic [3:0]  code;
        logic [1:0]  relay;
        logic        r3ph;
        logic [1:0]  lock;
        logic        rclr;
        logic        erst;
        logic [9:0]  duty;
        logic        cpen;
        logic [2:0]  st;
        logic        last;
    } pilot_out_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic [2:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [0:0] m_axis_tuser;
    logic m_axis_tlast;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    evse_control_pilot_fsm i_dut (.*);

    always #5 clk = ~clk;

    // predictor state
    logic c3ph, cvent, crcd;
    logic [31:0] cstop, clock_rel;
    logic [2:0] cur_st, prev_st;
    logic pwm_run, pwm_was, pw_allow, simp, latch3, cp_en;
    logic [9:0] duty_st;
    logic stop_run, lock_run;
    logic [31:0] stop_t0, lock_t0;

    // per-step scratch
    logic relay_on, sw_ok;
    logic [31:0] now_t;
    logic [1:0] relay_c, lock_c;
    logic r3, rclr, erst;
    int n_ev;

    step_t pending_steps[$];
    pilot_out_t expected_outs[$];
    int errors = 0;
    int cycles = 0;
    int gap_in = 0;
    int gap_out = 0;
    logic in_acc = 1'b0;

    function automatic bit near(int v, int c);
        return v > c - 1100 && v < c + 1100;
    endfunction

    task automatic queue_event(logic [3:0] code);
        pilot_out_t o;
        if (n_ev < 5)
        begin
            o = '0;
            o.evv = 1'b1;
            o.code = code;
            expected_outs.push_back(o);
            n_ev++;
        end
    endtask

    task automatic relay_close();
        if (!relay_on)
        begin
            relay_c = RELAY_CLOSE;
            r3 = latch3;
            queue_event(sw_ok ? EV_POWER_ON : EV_RELAY_ERR);
            if (sw_ok) relay_on = 1'b1;
            lock_c = LOCK_LOCK;
            lock_run = 1'b1;
            lock_t0 = now_t;
        end
    endtask

    task automatic relay_open();
        if (relay_on)
        begin
            relay_c = RELAY_OPEN;
            r3 = 1'b0;
            queue_event(sw_ok ? EV_POWER_OFF : EV_RELAY_ERR);
            if (sw_ok) relay_on = 1'b0;
            lock_c = LOCK_UNLOCK;
            lock_run = 1'b1;
            lock_t0 = now_t;
        end
    endtask

    task automatic stop_pwm();
        duty_st = DUTY_FULL;
        pwm_run = 1'b0;
        pw_allow = 1'b0;
    endtask

    task automatic pwm_stopped();
        if (pwm_was)
        begin
            stop_run = 1'b1;
            stop_t0 = now_t;
        end
        if (stop_run && (now_t - stop_t0) >= cstop) relay_open();
    endtask

    function automatic bit classify(int hi, int lo, output logic [2:0] st);
        st = ST_DIS;
        if (cur_st == ST_DIS) return 1;
        if (pwm_run && !near(lo, -12000))
        begin
            if (near(lo, 0) && near(hi, 0)) st = ST_E;
            else if (near(hi + lo, 0)) st = ST_DF;
            else return 0;
        end
        else if (near(hi, 12000)) st = ST_A;
        else if (near(hi, 9000)) st = ST_B;
        else if (near(hi, 6000)) st = ST_C;
        else if (near(hi, 3000)) st = ST_D;
        else if (near(hi, -12000)) st = ST_F;
        else return 0;
        return 1;
    endfunction

    task automatic run_pilot();
        bit pbcd, pef;
        pbcd = prev_st inside {ST_B, ST_C, ST_D};
        pef = prev_st inside {ST_E, ST_F};
        case (cur_st)
            ST_DIS:
            begin
                pw_allow = 1'b0;
                relay_open();
            end
            ST_A:
            begin
                latch3 = c3ph;
                stop_pwm();
                simp = 1'b0;
                if (!(prev_st inside {ST_A, ST_DIS, ST_F}))
                begin
                    queue_event(EV_REQ_STOP);
                    relay_open();
                    queue_event(EV_UNPLUGGED);
                    if (crcd)
                    begin
                        erst = 1'b1;
                        rclr = 1'b1;
                    end
                end
            end
            ST_B:
            begin
                if (!(prev_st inside {ST_A, ST_B}))
                begin
                    queue_event(EV_REQ_STOP);
                    relay_open();
                end
                if (prev_st inside {ST_A, ST_DIS})
                begin
                    queue_event(EV_PLUGGED);
                    simp = 1'b0;
                end
                if (pef) queue_event(EV_EF_TO_BCD);
            end
            ST_C:
            begin
                if (prev_st == ST_A)
                begin
                    queue_event(EV_PLUGGED);
                    simp = 1'b1;
                end
                if (prev_st == ST_B) queue_event(EV_REQ_POWER);
                if (pef) queue_event(EV_EF_TO_BCD);
                if (!pwm_run) pwm_stopped();
                else if (pw_allow)
                begin
                    relay_close();
                    if (!pwm_was && simp) queue_event(EV_REQ_POWER);
                end
            end
            ST_D:
            begin
                if (prev_st == ST_A)
                begin
                    queue_event(EV_PLUGGED);
                    queue_event(EV_REQ_POWER);
                    simp = 1'b1;
                end
                if (prev_st == ST_B) queue_event(EV_REQ_POWER);
                if (pef) queue_event(EV_EF_TO_BCD);
                if (!pwm_run) pwm_stopped();
                else
                begin
                    if (pw_allow && !relay_on)
                    begin
                        if (!cvent) queue_event(EV_NO_VENT);
                        else relay_close();
                    end
                    if (prev_st == ST_C && !cvent) queue_event(EV_NO_VENT);
                end
            end
            ST_E:
            begin
                if (prev_st != ST_E) queue_event(EV_ERR_E);
                if (pbcd) queue_event(EV_BCD_TO_EF);
                relay_open();
                stop_pwm();
            end
            ST_F:
            begin
                relay_open();
                if (pbcd) queue_event(EV_BCD_TO_EF);
            end
            default:
            begin
                if (prev_st != ST_DF) queue_event(EV_ERR_DF);
                if (pbcd) queue_event(EV_BCD_TO_EF);
                relay_open();
            end
        endcase
        prev_st = cur_st;
        pwm_was = pwm_run;
    endtask

    task automatic predict_step(step_t s);
        pilot_out_t o;
        logic [2:0] st;
        n_ev = 0;
        relay_on = s.rclosed;
        sw_ok = s.rok;
        now_t = s.now;
        relay_c = RELAY_NONE;
        lock_c = LOCK_NONE;
        r3 = 1'b0;
        rclr = 1'b0;
        erst = 1'b0;
        case (s.mode)
            MODE_STEP:
            begin
                if (s.rcd)
                begin
                    rclr = 1'b1;
                    queue_event(EV_RCD_ERR);
                end
                if (lock_run && (now_t - lock_t0) >= clock_rel)
                begin
                    lock_c = LOCK_UNLOCK;
                    lock_run = 1'b0;
                end
                if (s.cpv && classify($signed(s.hi), $signed(s.lo), st))
                begin
                    cur_st = st;
                    run_pilot();
                end
            end
            MODE_ENABLE:
            begin
                cur_st = ST_A;
                stop_pwm();
                cp_en = 1'b1;
            end
            MODE_DISABLE:
            begin
                cur_st = ST_DIS;
                stop_pwm();
                cp_en = 1'b0;
            end
            MODE_PWM_ON:
            begin
                duty_st = s.duty > 1000 ? DUTY_FULL : s.duty;
                pwm_run = 1'b1;
            end
            MODE_PWM_OFF: stop_pwm();
            MODE_PWM_F:
            begin
                duty_st = '0;
                cur_st = ST_F;
                pwm_run = 1'b0;
                pw_allow = 1'b0;
            end
            MODE_ALLOW: pw_allow = 1'b1;
            default: pw_allow = 1'b0;
        endcase
        o = '0;
        o.relay = relay_c;
        o.r3ph = relay_c == RELAY_CLOSE ? r3 : 1'b0;
        o.lock = lock_c;
        o.rclr = rclr;
        o.erst = erst;
        o.duty = duty_st;
        o.cpen = cp_en;
        o.st = cur_st;
        o.last = 1'b1;
        expected_outs.push_back(o);
    endtask

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_acc)
            begin
                predict_step(pending_steps.pop_front());
                gap_in = $urandom_range(0, 8);
            end
            if (!(s_axis_tvalid && !in_acc))
            begin
                if (gap_in > 0 || pending_steps.size() == 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    if (gap_in > 0) gap_in--;
                end
                else
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= pending_steps[0].mode;
                    s_axis_tdata <= {4'b0, pending_steps[0].duty, pending_steps[0].now,
                        pending_steps[0].rok, pending_steps[0].rclosed, pending_steps[0].rcd,
                        pending_steps[0].cpv, pending_steps[0].lo, pending_steps[0].hi};
                end
            end
            if (gap_out > 0)
            begin
                m_axis_tready <= 1'b0;
                gap_out--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        pilot_out_t a, e;
        cycles++;
        in_acc = rst_n && s_axis_tvalid && s_axis_tready;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            a = {m_axis_tuser[0], m_axis_tdata[3:0], m_axis_tdata[5:4], m_axis_tdata[6],
                m_axis_tdata[8:7], m_axis_tdata[9], m_axis_tdata[10], m_axis_tdata[20:11],
                m_axis_tdata[21], m_axis_tdata[24:22], m_axis_tlast};
            gap_out = $urandom_range(0, 8);
            if ($urandom_range(0, 3) == 0) gap_out = 0;
            if (expected_outs.size() == 0)
            begin
                $error("unexpected transfer %h", a);
                errors++;
            end
            else
            begin
                e = expected_outs.pop_front();
                if (a.evv !== e.evv) $error("event_valid exp %0d got %0d", e.evv, a.evv);
                if (a.code !== e.code) $error("event_code exp %0d got %0d", e.code, a.code);
                if (a.relay !== e.relay) $error("relay_cmd exp %0d got %0d", e.relay, a.relay);
                if (a.r3ph !== e.r3ph)
                    $error("relay_three_phase exp %0d got %0d", e.r3ph, a.r3ph);
                if (a.lock !== e.lock) $error("lock_cmd exp %0d got %0d", e.lock, a.lock);
                if (a.rclr !== e.rclr)
                    $error("rcd_flag_clear exp %0d got %0d", e.rclr, a.rclr);
                if (a.erst !== e.erst)
                    $error("emergency_reset exp %0d got %0d", e.erst, a.erst);
                if (a.duty !== e.duty) $error("pwm_duty_out exp %0d got %0d", e.duty, a.duty);
                if (a.cpen !== e.cpen)
                    $error("cp_enable_out exp %0d got %0d", e.cpen, a.cpen);
                if (a.st !== e.st) $error("cp_state exp %0d got %0d", e.st, a.st);
                if (a.last !== e.last) $error("last exp %0d got %0d", e.last, a.last);
                if (a !== e) errors++;
            end
        end
        if (cycles > 200000)
        begin
            $display("evse_control_pilot_fsm_tb: done, errors");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_THREE_PHASE: c3ph = val[0];
            CFG_VENT: cvent = val[0];
            CFG_RCD_RECLOSE: crcd = val[0];
            CFG_PWM_STOP: cstop = val;
            default: clock_rel = val;
        endcase
    endtask

    task automatic wait_idle();
        while (pending_steps.size() != 0 || expected_outs.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [14:0] volt_near(int c);
        int v;
        case ($urandom_range(0, 9))
            0: v = c - 1100 + $urandom_range(0, 1);
            1: v = c + 1100 - $urandom_range(0, 1);
            2: v = $urandom_range(0, 32000) - 16000;
            default: v = c + $urandom_range(0, 2000) - 1000;
        endcase
        return 15'(v);
    endfunction

    function automatic step_t rand_step(logic [31:0] t);
        step_t s;
        int c;
        int lvl[6] = '{12000, 9000, 6000, 3000, -12000, 0};
        s = '0;
        s.mode = $urandom_range(0, 2) != 0 ? MODE_STEP : 3'($urandom_range(1, 7));
        c = lvl[$urandom_range(0, 5)];
        s.hi = volt_near(c);
        case ($urandom_range(0, 3))
            0: s.lo = volt_near(0);
            1: s.lo = volt_near(-c);
            2: s.lo = 15'($urandom);
            default: s.lo = volt_near(-12000);
        endcase
        s.cpv = $urandom_range(0, 9) != 0;
        s.rcd = $urandom_range(0, 7) == 0;
        s.rclosed = 1'($urandom_range(0, 1));
        s.rok = $urandom_range(0, 4) != 0;
        s.now = $urandom_range(0, 9) == 0 ? $urandom : t;
        s.duty = $urandom_range(0, 5) == 0 ? 10'($urandom) : 10'($urandom_range(0, 1000));
        return s;
    endfunction

    function automatic step_t mk(logic [2:0] m, int hi, int lo, logic [31:0] t);
        step_t s;
        s = '0;
        s.mode = m;
        s.hi = 15'(hi);
        s.lo = 15'(lo);
        s.cpv = 1'b1;
        s.rok = 1'b1;
        s.now = t;
        s.duty = 10'd500;
        return s;
    endfunction

    initial
    begin
        step_t s;
        logic [31:0] t;
        c3ph = 1'b0; cvent = 1'b0; crcd = 1'b1; cstop = 32'd6000; clock_rel = 32'd1000;
        cur_st = ST_DIS; prev_st = ST_DIS;
        pwm_run = 1'b0; pwm_was = 1'b0; pw_allow = 1'b0; simp = 1'b0; latch3 = 1'b0;
        cp_en = 1'b0;
        duty_st = DUTY_FULL; stop_run = 1'b0; stop_t0 = '0; lock_run = 1'b0; lock_t0 = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        write_reg(CFG_THREE_PHASE, 1);
        write_reg(CFG_VENT, 0);
        write_reg(CFG_RCD_RECLOSE, 1);
        write_reg(CFG_PWM_STOP, 50);
        write_reg(CFG_LOCK_REL, 0);

        // directed: disabled, plug, charge, vent, errors, unplug
        pending_steps.push_back(mk(MODE_STEP, 12000, -12000, 1));
        pending_steps.push_back(mk(MODE_ENABLE, 0, 0, 2));
        pending_steps.push_back(mk(MODE_STEP, 12000, -12000, 3));
        pending_steps.push_back(mk(MODE_STEP, 9000, -12000, 4));
        s = mk(MODE_PWM_ON, 0, 0, 5); s.duty = 10'd1023;
        pending_steps.push_back(s);
        pending_steps.push_back(mk(MODE_ALLOW, 0, 0, 6));
        pending_steps.push_back(mk(MODE_STEP, 6000, -12000, 7));
        pending_steps.push_back(mk(MODE_STEP, 3000, -12000, 8));
        s = mk(MODE_STEP, 6000, -12000, 9); s.rclosed = 1; s.rcd = 1;
        pending_steps.push_back(s);
        s = mk(MODE_STEP, 0, 0, 10); s.rclosed = 1; s.rok = 0;
        pending_steps.push_back(s);
        pending_steps.push_back(mk(MODE_STEP, 9000, -12000, 11));
        pending_steps.push_back(mk(MODE_PWM_ON, 0, 0, 12));
        s = mk(MODE_STEP, 5000, -5000, 13); s.rclosed = 1;
        pending_steps.push_back(s);
        pending_steps.push_back(mk(MODE_STEP, 16000, 16000, 14));
        s = mk(MODE_STEP, -16000, -16000, 15); s.cpv = 0;
        pending_steps.push_back(s);
        pending_steps.push_back(mk(MODE_PWM_F, 0, 0, 16));
        pending_steps.push_back(mk(MODE_STEP, -12000, -12000, 17));
        pending_steps.push_back(mk(MODE_STEP, 12000, -12000, 18));
        pending_steps.push_back(mk(MODE_DENY, 0, 0, 19));
        pending_steps.push_back(mk(MODE_PWM_OFF, 0, 0, 20));
        s = mk(MODE_STEP, 6000, -12000, 21); s.rclosed = 1;
        pending_steps.push_back(s);
        pending_steps.push_back(mk(MODE_DISABLE, 0, 0, 22));
        wait_idle();

        t = 100;
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                1:
                begin
                    write_reg(CFG_THREE_PHASE, 0); write_reg(CFG_VENT, 1);
                    write_reg(CFG_RCD_RECLOSE, 0); write_reg(CFG_PWM_STOP, 0);
                    write_reg(CFG_LOCK_REL, 32'hFFFF_FFFF);
                end
                2:
                begin
                    write_reg(CFG_PWM_STOP, 32'hFFFF_FFFF); write_reg(CFG_LOCK_REL, 30);
                    write_reg(CFG_RCD_RECLOSE, 1);
                end
                3:
                begin
                    write_reg(CFG_PWM_STOP, 40); write_reg(CFG_VENT, 0);
                    write_reg(CFG_THREE_PHASE, 1);
                end
                default: ;
            endcase
            pending_steps.push_back(mk(MODE_ENABLE, 0, 0, t));
            for (int k = 0; k < 52; k++)
            begin
                t = t + $urandom_range(0, 20);
                pending_steps.push_back(rand_step(t));
                if (k == 25 && ph == 1)
                begin
                    wait_idle();
                end
            end
            wait_idle();
        end
        if (errors == 0)
            $display("evse_control_pilot_fsm_tb: done, clean");
        else
            $display("evse_control_pilot_fsm_tb: done, errors");
        $finish;
    end
endmodule

### filelist.f
src/evcp_pkg.sv
src/evcp_front.sv
src/evcp_queue.sv
src/evcp_back.sv
src/evse_control_pilot_fsm.sv
src/evcp_checker.sv
bench/evse_control_pilot_fsm_tb.sv
